/* hdl/pst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PE section table validator package
// Shared types, status codes, register indexes and the name check function.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    CFG_IMAGE_SIZE   = 2'd0,
    CFG_HEADERS_SIZE = 2'd1,
    CFG_FILE_SIZE    = 2'd2
  } cfg_index_e;

  typedef enum logic [3:0] {
    STS_OK            = 4'd0,
    STS_UNSAFE_NAME   = 4'd1,
    STS_EMPTY_NAME    = 4'd2,
    STS_BAD_PADDING   = 4'd3,
    STS_VIRT_OUTSIDE  = 4'd4,
    STS_VIRT_OVERLAP  = 4'd5,
    STS_RAW_OUTSIDE   = 4'd6,
    STS_RAW_OVERLAP   = 4'd7,
    STS_BAD_EMPTY_OFF = 4'd8,
    STS_SECOND_TEXT   = 4'd9,
    STS_TEXT_NO_DATA  = 4'd10,
    STS_TEXT_MISSING  = 4'd11,
    STS_SKIPPED       = 4'd12,
    STS_TABLE_FULL    = 4'd13
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_VSCAN  = 7'b0000100,
    S_RSTART = 7'b0001000,
    S_RSCAN  = 7'b0010000,
    S_TEXT   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } span_t;

  localparam int unsigned SPAN_W = $bits(span_t);

  localparam logic [7:0]  NAME_CHAR_MIN = 8'h20;
  localparam logic [7:0]  NAME_CHAR_MAX = 8'h7E;
  localparam logic [63:0] TEXT_NAME     = 64'h0000_0074_7865_742E;

  // The name ends at the first zero byte; printable bytes before it, zeros after it.
  function automatic status_e check_name(input logic [63:0] name);
    logic       ended;
    logic       unsafe;
    logic       pad_bad;
    logic [7:0] b;
    status_e    sts;
    ended   = 1'b0;
    unsafe  = 1'b0;
    pad_bad = 1'b0;
    for (int k = 0; k < 8; k++) begin
      b = name[8*k +: 8];
      if (!ended) begin
        if (b == 8'h00) begin
          ended = 1'b1;
        end else if (b < NAME_CHAR_MIN || b > NAME_CHAR_MAX) begin
          unsafe = 1'b1;
        end
      end else if (b != 8'h00) begin
        pad_bad = 1'b1;
      end
    end
    if (unsafe) begin
      sts = STS_UNSAFE_NAME;
    end else if (name[7:0] == 8'h00) begin
      sts = STS_EMPTY_NAME;
    end else if (pad_bad) begin
      sts = STS_BAD_PADDING;
    end else begin
      sts = STS_OK;
    end
    return sts;
  endfunction

endpackage
`default_nettype wire

/* hdl/pe_section_table_validator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PE section table validator
// Checks one PE32 section header per transfer against the image registers and
// against the virtual and raw ranges stored earlier for the same image.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                Payload
//  in       sink       in_valid_i / in_stall_o  first, last, name, sizes, addresses
//  out      source     out_valid_o / out_stall_i  status, is_text, image_done
//  cfg      sink       cfg_we_i                 cfg_index_i, cfg_wdata_i
//
//  The time a section that passes every check takes from its input transfer to the
//  next one is set by the scans of the two range memories at one entry per cycle.
//  Items are processed one at a time; the input stalls while an item is active.
//  A finished result waits in the output register while the next item starts.
//  Reset clears the counts and flags; the range memories need no clearing pass.
// ----------------------------------------------------------------------------
module pe_section_table_validator #(
  parameter int unsigned MAX_SECTIONS = 96
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        in_first_section_i,
  input  wire logic        in_last_section_i,
  input  wire logic [63:0] in_name_bytes_i,
  input  wire logic [31:0] in_virtual_size_i,
  input  wire logic [31:0] in_virtual_address_i,
  input  wire logic [31:0] in_raw_size_i,
  input  wire logic [31:0] in_raw_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       out_status_o,
  output logic             out_is_text_o,
  output logic             out_image_done_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_SECTIONS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SECTIONS);

  logic [31:0] image_size_q, headers_size_q, file_size_q;

  pst_pkg::state_e  state_q, state_d;
  pst_pkg::status_e status_q, status_d;

  logic [CW-1:0] vcount_q, vcount_d, rcount_q, rcount_d, seen_q, seen_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          text_q, text_d, rej_q, rej_d;
  logic          rd_valid_q, rd_valid_d, hit_q, hit_d;
  logic          out_valid_q, out_valid_d;

  logic             last_q, is_text_q;
  pst_pkg::status_e name_sts_q;
  logic [31:0]      vsize_q, vaddr_q, rsize_q, roff_q;
  logic [31:0]      cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
  logic [3:0]       out_status_q;
  logic             out_is_text_q, out_image_done_q;

  logic          in_xfer, out_free, load_out;
  logic [32:0]   vsum, rsum;
  logic          vout, rout;
  logic [CW-1:0] scan_cnt;
  logic          rd_en, scan_end;
  pst_pkg::span_t vram_rdata, rram_rdata, entry;
  logic          vram_we, rram_we;

  assign in_stall_o = (state_q != pst_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == pst_pkg::S_FINISH) && out_free;

  assign vsum = {1'b0, vaddr_q} + {1'b0, vsize_q};
  assign rsum = {1'b0, roff_q} + {1'b0, rsize_q};
  assign vout = vsum[32] || (vaddr_q >= image_size_q) || (vsum[31:0] > image_size_q);
  assign rout = rsum[32] || (roff_q < headers_size_q) || (rsum[31:0] > file_size_q);

  assign scan_cnt = (state_q == pst_pkg::S_VSCAN) ? vcount_q : rcount_q;
  assign rd_en    = ((state_q == pst_pkg::S_VSCAN) || (state_q == pst_pkg::S_RSCAN)) &&
                    (idx_q < scan_cnt);
  assign scan_end = !rd_en && !rd_valid_q;
  assign entry    = (state_q == pst_pkg::S_VSCAN) ? vram_rdata : rram_rdata;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    vcount_d    = vcount_q;
    rcount_d    = rcount_q;
    seen_d      = seen_q;
    idx_d       = idx_q;
    text_d      = text_q;
    rej_d       = rej_q;
    rd_valid_d  = 1'b0;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    cur_lo_d    = cur_lo_q;
    cur_hi_d    = cur_hi_q;
    vram_we     = 1'b0;
    rram_we     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      pst_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_first_section_i) begin
            vcount_d = '0;
            rcount_d = '0;
            seen_d   = '0;
            text_d   = 1'b0;
            rej_d    = 1'b0;
          end
          state_d = pst_pkg::S_CHECK;
        end
      end
      pst_pkg::S_CHECK: begin
        idx_d   = '0;
        hit_d   = 1'b0;
        state_d = pst_pkg::S_FINISH;
        if (rej_q) begin
          status_d = pst_pkg::STS_SKIPPED;
        end else if (seen_q >= MAX_CNT) begin
          status_d = pst_pkg::STS_TABLE_FULL;
        end else begin
          seen_d   = seen_q + 1'b1;
          status_d = name_sts_q;
          if (name_sts_q == pst_pkg::STS_OK) begin
            if (vsize_q == '0) begin
              state_d = pst_pkg::S_RSTART;
            end else if (vout) begin
              status_d = pst_pkg::STS_VIRT_OUTSIDE;
            end else begin
              cur_lo_d = vaddr_q;
              cur_hi_d = vsum[31:0];
              state_d  = pst_pkg::S_VSCAN;
            end
          end
        end
      end
      pst_pkg::S_VSCAN, pst_pkg::S_RSCAN: begin
        if (rd_en) begin
          idx_d = idx_q + 1'b1;
        end
        rd_valid_d = rd_en;
        if (rd_valid_q && (entry.lo < cur_hi_q) && (cur_lo_q < entry.hi)) begin
          hit_d = 1'b1;
        end
        if (scan_end) begin
          if (state_q == pst_pkg::S_VSCAN) begin
            if (hit_q) begin
              status_d = pst_pkg::STS_VIRT_OVERLAP;
              state_d  = pst_pkg::S_FINISH;
            end else begin
              vram_we  = 1'b1;
              vcount_d = vcount_q + 1'b1;
              state_d  = pst_pkg::S_RSTART;
            end
          end else begin
            if (hit_q) begin
              status_d = pst_pkg::STS_RAW_OVERLAP;
              state_d  = pst_pkg::S_FINISH;
            end else begin
              rram_we  = 1'b1;
              rcount_d = rcount_q + 1'b1;
              state_d  = pst_pkg::S_TEXT;
            end
          end
        end
      end
      pst_pkg::S_RSTART: begin
        idx_d = '0;
        hit_d = 1'b0;
        if (rsize_q != '0) begin
          if (rout) begin
            status_d = pst_pkg::STS_RAW_OUTSIDE;
            state_d  = pst_pkg::S_FINISH;
          end else begin
            cur_lo_d = roff_q;
            cur_hi_d = rsum[31:0];
            state_d  = pst_pkg::S_RSCAN;
          end
        end else if (roff_q > file_size_q) begin
          status_d = pst_pkg::STS_BAD_EMPTY_OFF;
          state_d  = pst_pkg::S_FINISH;
        end else begin
          state_d = pst_pkg::S_TEXT;
        end
      end
      pst_pkg::S_TEXT: begin
        state_d = pst_pkg::S_FINISH;
        if (is_text_q && text_q) begin
          status_d = pst_pkg::STS_SECOND_TEXT;
        end else if (is_text_q && (rsize_q == '0)) begin
          status_d = pst_pkg::STS_TEXT_NO_DATA;
        end else if (is_text_q) begin
          text_d = 1'b1;
        end else if (last_q && !text_q) begin
          status_d = pst_pkg::STS_TEXT_MISSING;
        end
      end
      pst_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (status_q != pst_pkg::STS_OK) begin
            rej_d = 1'b1;
          end
          state_d = pst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= pst_pkg::S_IDLE;
      vcount_q       <= '0;
      rcount_q       <= '0;
      seen_q         <= '0;
      idx_q          <= '0;
      text_q         <= 1'b0;
      rej_q          <= 1'b0;
      rd_valid_q     <= 1'b0;
      hit_q          <= 1'b0;
      out_valid_q    <= 1'b0;
      image_size_q   <= '0;
      headers_size_q <= '0;
      file_size_q    <= '0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      rcount_q    <= rcount_d;
      seen_q      <= seen_d;
      idx_q       <= idx_d;
      text_q      <= text_d;
      rej_q       <= rej_d;
      rd_valid_q  <= rd_valid_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pst_pkg::CFG_IMAGE_SIZE:   image_size_q   <= cfg_wdata_i;
          pst_pkg::CFG_HEADERS_SIZE: headers_size_q <= cfg_wdata_i;
          pst_pkg::CFG_FILE_SIZE:    file_size_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    cur_lo_q <= cur_lo_d;
    cur_hi_q <= cur_hi_d;
    if (in_xfer) begin
      last_q     <= in_last_section_i;
      is_text_q  <= (in_name_bytes_i == pst_pkg::TEXT_NAME);
      name_sts_q <= pst_pkg::check_name(in_name_bytes_i);
      vsize_q    <= in_virtual_size_i;
      vaddr_q    <= in_virtual_address_i;
      rsize_q    <= in_raw_size_i;
      roff_q     <= in_raw_offset_i;
    end
    if (load_out) begin
      out_status_q     <= status_q;
      out_is_text_q    <= is_text_q;
      out_image_done_q <= last_q;
    end
  end

  pst_ram #(
    .WIDTH(pst_pkg::SPAN_W),
    .DEPTH(MAX_SECTIONS)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (vram_we),
    .waddr_i(vcount_q[AW-1:0]),
    .wdata_i({cur_hi_q, cur_lo_q}),
    .re_i   (rd_en && (state_q == pst_pkg::S_VSCAN)),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(vram_rdata)
  );

  pst_ram #(
    .WIDTH(pst_pkg::SPAN_W),
    .DEPTH(MAX_SECTIONS)
  ) u_rram (
    .clk_i  (clk_i),
    .we_i   (rram_we),
    .waddr_i(rcount_q[AW-1:0]),
    .wdata_i({cur_hi_q, cur_lo_q}),
    .re_i   (rd_en && (state_q == pst_pkg::S_RSCAN)),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(rram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_is_text_o    = out_is_text_q;
  assign out_image_done_o = out_image_done_q;

`ifndef ASSERT_OFF
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vcount_q <= seen_q) && (rcount_q <= seen_q) && (seen_q <= MAX_CNT))
    else $error("stored range counts exceed the sections seen");

  a_rej_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej_q && !(in_xfer && in_first_section_i) |=> rej_q)
    else $error("rejected flag cleared without a new image");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (state_q == pst_pkg::S_VSCAN) || (state_q == pst_pkg::S_RSCAN))
    else $error("memory read data pending outside a scan");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && (state_q == pst_pkg::S_IDLE))
    else $error("finished result was not presented");
`endif

endmodule
`default_nettype wire

/* hdl/pst_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 96,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
